[hdl/luhn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_pkg
// types, constants and digit arithmetic shared by the luhn checker
// ----------------------------------------------------------------------------
package luhn_pkg;

  localparam int unsigned DigitW = 4;
  localparam int unsigned CountW = 5;

  localparam logic [CountW-1:0] CountMax  = 5'd31;
  localparam logic [DigitW-1:0] Radix     = 4'd10;
  localparam logic [4:0]        RadixW5   = 5'd10;
  localparam logic [4:0]        FoldBack  = 5'd9;

  localparam logic [CountW-1:0] Len13 = 5'd13;
  localparam logic [CountW-1:0] Len14 = 5'd14;
  localparam logic [CountW-1:0] Len15 = 5'd15;
  localparam logic [CountW-1:0] Len16 = 5'd16;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              last_digit;
  } luhn_in_t;

  typedef struct packed {
    logic valid_res;
    logic length_ok;
    logic check_ok;
  } luhn_out_t;

  // doubled digit, folded by 9 when two digits, then mod 10
  // (a raw code of 15 folds to 21, which needs two steps of 10)
  function automatic logic [DigitW-1:0] luhn_double(input logic [DigitW-1:0] d);
    logic [4:0] v;
    v = {d, 1'b0};
    if (v >= RadixW5) v = v - FoldBack;
    if (v >= RadixW5) v = v - RadixW5;
    if (v >= RadixW5) v = v - RadixW5;
    return v[DigitW-1:0];
  endfunction

  // raw digit mod 10, covers codes above 9
  function automatic logic [DigitW-1:0] luhn_mod10(input logic [DigitW-1:0] d);
    return (d >= Radix) ? d - Radix : d;
  endfunction

  // both operands below 10
  function automatic logic [DigitW-1:0] luhn_add10(input logic [DigitW-1:0] a,
                                                   input logic [DigitW-1:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= RadixW5) s = s - RadixW5;
    return s[DigitW-1:0];
  endfunction

  // prefix and length rule
  function automatic logic luhn_len_rule(input logic [DigitW-1:0] first,
                                         input logic [CountW-1:0] len);
    logic ok;
    case (first) inside
      4'd3:       ok = (len == Len14) || (len == Len15);
      4'd4:       ok = (len == Len13) || (len == Len16);
      4'd5, 4'd6: ok = (len == Len16);
      default:    ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

[hdl/luhn_card_number_checker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_card_number_checker_unit
// streaming luhn mod-10 and prefix/length check of a card number
// ----------------------------------------------------------------------------
// Digits enter one item per clock while in_stall_o is low, most significant
// first, with last_digit set on the check digit. Each accepted digit updates
// the two running mod-10 sums, the first digit and the saturating count in
// a single register stage, so a new number may start in the cycle after the
// previous check digit. One result item appears on the output register in
// the cycle after the check digit is accepted. Input stall is raised only
// while a result is held in the output register and the downstream side
// stalls it. Numbers of 31 digits or more always fail the length rule; digit
// codes 10 to 15 are summed mod 10 and never pass as a check digit.
// ----------------------------------------------------------------------------
module luhn_card_number_checker_unit
  import luhn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  luhn_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output luhn_out_t out_data_o
);

  // running state of the number in flight
  logic [DigitW-1:0] first_q, first_d;
  logic [CountW-1:0] count_q, count_d;
  logic [DigitW-1:0] sum_odd_q, sum_odd_d;
  logic [DigitW-1:0] sum_even_q, sum_even_d;

  // result register
  logic      out_valid_q, out_valid_d;
  luhn_out_t out_data_q, out_data_d;

  logic              in_fire;
  logic              res_load;
  logic [DigitW-1:0] first_now;
  logic [CountW-1:0] len_now;
  logic [DigitW-1:0] check_dig;

  // only a held, stalled result blocks the input
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign res_load   = in_fire && in_data_i.last_digit;

  always_comb begin
    // first digit counts when nothing has been seen yet
    first_now = (count_q == '0) ? in_data_i.digit : first_q;
    len_now   = (count_q < CountMax) ? count_q + 1'b1 : CountMax;
    // check digit is (10 - sum) mod 10
    check_dig = (sum_odd_q == '0) ? '0 : Radix - sum_odd_q;

    first_d    = first_q;
    count_d    = count_q;
    sum_odd_d  = sum_odd_q;
    sum_even_d = sum_even_q;
    if (in_fire) begin
      if (in_data_i.last_digit) begin
        // clear for the next number
        first_d    = '0;
        count_d    = '0;
        sum_odd_d  = '0;
        sum_even_d = '0;
      end else begin
        // sums swap parity roles on every digit
        first_d    = first_now;
        sum_odd_d  = luhn_add10(sum_even_q, luhn_double(in_data_i.digit));
        sum_even_d = luhn_add10(sum_odd_q, luhn_mod10(in_data_i.digit));
        count_d    = (count_q < CountMax) ? count_q + 1'b1 : count_q;
      end
    end
  end

  always_comb begin
    out_data_d.length_ok = luhn_len_rule(first_now, len_now);
    out_data_d.check_ok  = (in_data_i.digit == check_dig);
    out_data_d.valid_res = out_data_d.length_ok && out_data_d.check_ok;

    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      count_q     <= '0;
      sum_odd_q   <= '0;
      sum_even_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      count_q     <= count_d;
      sum_odd_q   <= sum_odd_d;
      sum_even_q  <= sum_even_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only with a check digit
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // a check digit always yields a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> out_valid_o)
    else $error("no result after check digit");

  // a plain digit never creates a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_data_i.last_digit && !(out_valid_o && out_stall_i)) |=> !out_valid_o)
    else $error("result without check digit");

  // state cleared after each number
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (count_q == '0) && (sum_odd_q == '0) && (sum_even_q == '0))
    else $error("state not cleared after check digit");

  // running sums stay reduced mod 10
  a_sums_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (sum_odd_q < Radix) && (sum_even_q < Radix))
    else $error("running sum out of range");
`endif

endmodule

[tb/luhn_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_result_checker
// watches both channels of the luhn checker, predicts each verdict from
// the accepted digits and compares it with the verdict that comes out
// ----------------------------------------------------------------------------
module luhn_result_checker
  import luhn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  luhn_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  luhn_out_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o
);

  // running state of the number being received
  logic [DigitW-1:0] lead_digit;
  logic [CountW-1:0] digits_seen;
  logic [DigitW-1:0] sum_odd;
  logic [DigitW-1:0] sum_even;

  luhn_out_t verdict_q[$];
  int        fails;
  int        checked;

  assign fail_count_o = fails;
  assign pending_o    = verdict_q.size();
  assign checked_o    = checked;

  // doubled digit, minus 9 when two digits, kept mod 10
  function automatic logic [DigitW-1:0] fold_double(input logic [DigitW-1:0] d);
    int v;
    v = 2 * int'(d);
    if (v >= 10) v = v - 9;
    return DigitW'(v % int'(Radix));
  endfunction

  function automatic logic prefix_len_ok(input logic [DigitW-1:0] lead,
                                         input logic [CountW-1:0] len);
    case (lead)
      4'd3:       return (len == Len14) || (len == Len15);
      4'd4:       return (len == Len13) || (len == Len16);
      4'd5, 4'd6: return (len == Len16);
      default:    return 1'b0;
    endcase
  endfunction

  function automatic void report(input string what, input luhn_out_t want,
                                 input luhn_out_t got);
    if (fails < 10)
      $display("[%0t] %s: expected valid=%0b len=%0b chk=%0b, got valid=%0b len=%0b chk=%0b",
               $time, what, want.valid_res, want.length_ok, want.check_ok,
               got.valid_res, got.length_ok, got.check_ok);
    fails++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict
    luhn_out_t         want;
    logic [DigitW-1:0] lead;
    logic [DigitW-1:0] d;
    logic [DigitW-1:0] tail;
    logic [CountW-1:0] len;
    if (!rst_ni) begin
      lead_digit  <= '0;
      digits_seen <= '0;
      sum_odd     <= '0;
      sum_even    <= '0;
      verdict_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      // results first, so an item accepted on the same edge cannot hide
      // a result that arrived with nothing waiting
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (verdict_q.size() == 0) begin
          report("result with nothing expected", '0, out_data_i);
        end else begin
          want = verdict_q.pop_front();
          if (out_data_i.valid_res !== want.valid_res ||
              out_data_i.length_ok !== want.length_ok ||
              out_data_i.check_ok  !== want.check_ok)
            report("mismatch", want, out_data_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        d    = in_data_i.digit;
        lead = (digits_seen == '0) ? d : lead_digit;
        if (!in_data_i.last_digit) begin
          lead_digit  <= lead;
          sum_odd     <= DigitW'((int'(sum_even) + int'(fold_double(d))) % int'(Radix));
          sum_even    <= DigitW'((int'(sum_odd) + int'(d) % int'(Radix)) % int'(Radix));
          if (digits_seen < CountMax) digits_seen <= digits_seen + 1'b1;
        end else begin
          len  = (digits_seen < CountMax) ? digits_seen + 1'b1 : CountMax;
          tail = DigitW'((int'(Radix) - int'(sum_odd)) % int'(Radix));
          want.length_ok = prefix_len_ok(lead, len);
          want.check_ok  = (d == tail);
          want.valid_res = want.length_ok && want.check_ok;
          verdict_q.push_back(want);
          // state clears for the next number
          lead_digit  <= '0;
          digits_seen <= '0;
          sum_odd     <= '0;
          sum_even    <= '0;
        end
      end
    end
  end

endmodule

[tb/luhn_card_number_checker_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_card_number_checker_unit_tb
// drives card numbers digit by digit into the luhn checker under random
// sender gaps and receiver stalls; a checker module beside the block
// predicts every verdict and counts failures
// ----------------------------------------------------------------------------
module luhn_card_number_checker_unit_tb;
  import luhn_pkg::*;

  // cycles with no item moving on either side before the run is called hung
  localparam int QuietLimit = 2000;
  localparam int DigitGoal  = 1550;

  logic      clk_i;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  luhn_in_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  luhn_out_t out_data;

  int fails;
  int pending;
  int checked;

  // sender bookkeeping
  int digits_sent;
  int numbers_sent;
  int burst_left;
  int quiet_cycles;

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  luhn_card_number_checker_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  luhn_result_checker u_result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // watchdog: any cycle in which an item moves on either channel resets it
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("FAIL luhn_card_number_checker_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: each stretch picks a stall mode, from never stalling to
  // mostly stalled, plus a fixed one-in-three pattern
  initial begin : receiver
    int mode;
    int span;
    int phase;
    phase = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk_i);
        phase++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (phase % 3 == 0);
        endcase
      end
    end
  end

  // luhn check digit for a body of plain decimal digits; the digit next
  // to the check digit is the first one doubled
  function automatic logic [DigitW-1:0] check_digit_for(input logic [DigitW-1:0] body[$]);
    int acc;
    int v;
    acc = 0;
    for (int k = 0; k < body.size(); k++) begin
      v = body[body.size() - 1 - k];
      if (k % 2 == 0) begin
        v = 2 * v;
        if (v > 9) v = v - 9;
      end
      acc += v;
    end
    return DigitW'((10 - acc % 10) % 10);
  endfunction

  // one digit item; called at a falling edge, returns at a falling edge.
  // valid drops only when a real gap follows, so it never falls and rises
  // in the same step
  task automatic put_digit(input logic [DigitW-1:0] d, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_data  <= '{digit: d, last_digit: fin};
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    digits_sent++;
  endtask

  task automatic send_number(input logic [DigitW-1:0] digs[$]);
    for (int k = 0; k < digs.size(); k++)
      put_digit(digs[k], k == digs.size() - 1);
    numbers_sent++;
  endtask

  // random card number: mostly well formed with a plausible prefix and
  // length, then loose decimal numbers, very long ones, single digits and
  // raw noise with digit codes up to 15
  task automatic random_number();
    logic [DigitW-1:0] digs[$];
    int kind;
    int len;
    int lead;
    kind = $urandom_range(0, 99);
    digs.delete();
    if (kind < 65) begin
      lead = $urandom_range(3, 6);
      case (lead)
        3:       len = $urandom_range(14, 15);
        4:       len = ($urandom_range(0, 1) == 0) ? 13 : 16;
        default: len = 16;
      endcase
      // near misses on the length
      if ($urandom_range(0, 4) == 0) len = len + $urandom_range(0, 4) - 2;
      digs.push_back(DigitW'(lead));
      while (digs.size() < len - 1) digs.push_back(DigitW'($urandom_range(0, 9)));
      if ($urandom_range(0, 3) != 0) digs.push_back(check_digit_for(digs));
      else                           digs.push_back(DigitW'($urandom_range(0, 9)));
    end else if (kind < 80) begin
      len = $urandom_range(2, 20);
      while (digs.size() < len - 1) digs.push_back(DigitW'($urandom_range(0, 9)));
      if ($urandom_range(0, 1) == 0) digs.push_back(check_digit_for(digs));
      else                           digs.push_back(DigitW'($urandom_range(0, 9)));
    end else if (kind < 85) begin
      // count saturates; luhn sum must still be exact
      len = $urandom_range(28, 40);
      digs.push_back(DigitW'($urandom_range(3, 6)));
      while (digs.size() < len - 1) digs.push_back(DigitW'($urandom_range(0, 9)));
      digs.push_back(check_digit_for(digs));
    end else if (kind < 90) begin
      digs.push_back(DigitW'($urandom_range(0, 15)));
    end else begin
      len = $urandom_range(1, 20);
      repeat (len) digs.push_back(DigitW'($urandom_range(0, 15)));
    end
    send_number(digs);
  endtask

  initial begin : stimulus
    bit paused;
    digits_sent  = 0;
    numbers_sent = 0;
    burst_left   = 0;
    paused       = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // directed: a well-formed visa-style number, single-digit numbers with
    // the smallest and largest digit codes, an out-of-range first digit and
    // check digit, and a two-digit number that passes luhn but not length
    send_number('{4'd4, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
                  4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1});
    send_number('{4'd0});
    send_number('{4'd15});
    send_number('{4'd10, 4'd9, 4'd15});
    send_number('{4'd9, 4'd1});

    while (digits_sent < DigitGoal) begin
      // once, halfway, hold off until every verdict is back
      if (!paused && digits_sent >= DigitGoal / 2) begin
        paused   = 1'b1;
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk_i);
        burst_left = 0;
      end
      random_number();
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk_i);

    $display("sent %0d card numbers as %0d digit items, checked %0d verdicts",
             numbers_sent, digits_sent, checked);
    if (fails == 0 && pending == 0) begin
      $display("PASS luhn_card_number_checker_unit");
    end else begin
      $display("%0d failures, %0d verdicts still expected", fails, pending);
      $display("FAIL luhn_card_number_checker_unit");
    end
    $finish;
  end

endmodule

[files.f]
hdl/luhn_pkg.sv
hdl/luhn_card_number_checker_unit.sv
tb/luhn_result_checker.sv
tb/luhn_card_number_checker_unit_tb.sv
